// ----- src/pcfsm_pkg.sv -----
package pcfsm_pkg;

	// Kind of input word, carried on s_tuser.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Coordinates with a neighbour offset and a sign, wide enough to compare against 1024.
	localparam int COORD_W = 12;

	localparam logic [3:0] TAP_LAST = 4'd8;
	localparam logic [3:0] DIV_TOP  = 4'd8;

	// light = (1546u + 3584p) / (20u); the divisor is kept pre-shifted by the top quotient bit.
	localparam logic [15:0] LIGHT_U_MUL = 16'd1546;
	localparam logic [15:0] LIGHT_P_MUL = 16'd3584;
	localparam logic [15:0] LIGHT_D_MUL = 16'd5120;
	localparam logic [8:0]  LIGHT_EMPTY = 9'd77;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic rd;
		logic prep;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last_tap;
		logic div_last;
	} status_t;

	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
	} offset_t;

	function automatic offset_t tap_offset(input logic [3:0] k);
		offset_t o;
		unique case (k)
			4'd0: o = '{dx: -2'sd1, dy: -2'sd1};
			4'd1: o = '{dx: -2'sd1, dy:  2'sd0};
			4'd2: o = '{dx: -2'sd1, dy:  2'sd1};
			4'd3: o = '{dx:  2'sd0, dy: -2'sd1};
			4'd4: o = '{dx:  2'sd0, dy:  2'sd0};
			4'd5: o = '{dx:  2'sd0, dy:  2'sd1};
			4'd6: o = '{dx:  2'sd1, dy: -2'sd1};
			4'd7: o = '{dx:  2'sd1, dy:  2'sd0};
			4'd8: o = '{dx:  2'sd1, dy:  2'sd1};
			default: o = '{dx: 2'sd0, dy: 2'sd0};
		endcase
		return o;
	endfunction

endpackage

// ----- src/pcfsm_ctrl.sv -----
module pcfsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                op,
	input  logic                m_tready,
	input  pcfsm_pkg::status_t  status,
	output pcfsm_pkg::cmd_t     cmd,
	output logic                s_tready,
	output logic                m_tvalid
);
	import pcfsm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op == OP_QUERY) begin
						cmd.load = 1'b1;
						state_d  = ST_READ;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				if (status.last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- src/pcfsm_dp.sv -----
module pcfsm_dp #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcfsm_pkg::cmd_t     cmd,
	output pcfsm_pkg::status_t  status,
	input  logic signed [9:0]   in_x,
	input  logic signed [9:0]   in_y,
	input  logic [15:0]         in_depth,
	input  logic                cfg_valid,
	input  logic [15:0]         cfg_data,
	output logic [3:0]          passing_count,
	output logic [3:0]          usable_count,
	output logic [8:0]          shadow_fraction,
	output logic [8:0]          light_scale
);
	import pcfsm_pkg::*;

	localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(CELLS);

	logic [15:0] mem [CELLS];

	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [15:0]               qdepth_q;
	logic signed [15:0]        bias_q;
	logic [3:0]                tap_q;
	logic [3:0]                step_q;
	logic                      smp_s1, on_s1;
	logic [15:0]               rd_data_s1;
	logic [3:0]                pass_q, use_q;
	logic [12:0]               rem_f_q, dsh_f_q;
	logic [15:0]               rem_l_q, dsh_l_q;
	logic [8:0]                quo_f_q, quo_l_q;

	offset_t                   off;
	logic signed [COORD_W-1:0] px, py;
	logic                      on;
	logic [AW-1:0]             addr;
	logic signed [17:0]        thr;
	logic                      hit;
	logic [12:0]               num_f;
	logic [15:0]               num_l;

	always_comb begin
		off = tap_offset(tap_q);
		if (cmd.rd) begin
			px = cx_q + {{(COORD_W-2){off.dx[1]}}, off.dx};
			py = cy_q + {{(COORD_W-2){off.dy[1]}}, off.dy};
		end else begin
			px = {{(COORD_W-10){in_x[9]}}, in_x};
			py = {{(COORD_W-10){in_y[9]}}, in_y};
		end
		on = (px >= 0) && (px < $signed(COORD_W'(MAP_WIDTH)))
			&& (py >= 0) && (py < $signed(COORD_W'(MAP_HEIGHT)));
		addr = AW'(AW'(px[9:0]) * AW'(MAP_HEIGHT) + AW'(py[9:0]));
		thr  = $signed({2'b00, qdepth_q}) + $signed({{2{bias_q[15]}}, bias_q});
		hit  = $signed({2'b00, rd_data_s1}) < thr;
		num_f = {pass_q, 9'b0} + 13'(use_q);
		num_l = 16'(use_q) * LIGHT_U_MUL + 16'(pass_q) * LIGHT_P_MUL;
	end

	// Single port: writes happen only while idle, reads only during the tap sweep.
	always_ff @(posedge clk) begin
		if (cmd.wr && on) begin
			mem[addr] <= in_depth;
		end
		if (cmd.rd && on) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			tap_q  <= '0;
			step_q <= '0;
			smp_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bias_q <= cfg_data;
			end
			if (cmd.load) begin
				tap_q <= '0;
			end else if (cmd.rd) begin
				tap_q <= tap_q + 4'd1;
			end
			if (cmd.prep) begin
				step_q <= DIV_TOP;
			end else if (cmd.step) begin
				step_q <= step_q - 4'd1;
			end
			smp_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q     <= {{(COORD_W-10){in_x[9]}}, in_x};
			cy_q     <= {{(COORD_W-10){in_y[9]}}, in_y};
			qdepth_q <= in_depth;
		end
		on_s1 <= on;
		if (cmd.load) begin
			pass_q <= '0;
			use_q  <= '0;
		end else if (smp_s1 && on_s1) begin
			use_q  <= use_q + 4'd1;
			pass_q <= pass_q + {3'b000, hit};
		end
		// Both quotients stay below 512, so nine restoring steps from bit 8 down suffice.
		if (cmd.prep) begin
			rem_f_q <= num_f;
			dsh_f_q <= {use_q, 9'b0};
			rem_l_q <= num_l;
			dsh_l_q <= 16'(use_q) * LIGHT_D_MUL;
			quo_f_q <= '0;
			quo_l_q <= '0;
		end else if (cmd.step) begin
			if (rem_f_q >= dsh_f_q) begin
				rem_f_q <= rem_f_q - dsh_f_q;
				quo_f_q <= {quo_f_q[7:0], 1'b1};
			end else begin
				quo_f_q <= {quo_f_q[7:0], 1'b0};
			end
			if (rem_l_q >= dsh_l_q) begin
				rem_l_q <= rem_l_q - dsh_l_q;
				quo_l_q <= {quo_l_q[7:0], 1'b1};
			end else begin
				quo_l_q <= {quo_l_q[7:0], 1'b0};
			end
			dsh_f_q <= dsh_f_q >> 1;
			dsh_l_q <= dsh_l_q >> 1;
		end
		if (cmd.load_out) begin
			passing_count <= pass_q;
			usable_count  <= use_q;
			if (use_q == 4'd0) begin
				shadow_fraction <= '0;
				light_scale     <= LIGHT_EMPTY;
			end else begin
				shadow_fraction <= quo_f_q;
				light_scale     <= quo_l_q;
			end
		end
	end

	assign status.last_tap = (tap_q == TAP_LAST);
	assign status.div_last = (step_q == 4'd0);

endmodule

// ----- src/pcf_shadow_map_query_core.sv -----
// Channel   Direction  Handshake                 Word
// s_*       in         s_tvalid / s_tready       tdata: map_x, map_y, depth; tuser: op
// m_*       out        m_tvalid / m_tready       tdata: passing, usable, fraction, light
// cfg_*     in         cfg_valid / cfg_ready     depth_bias, always ready
//
// A write word is handled in the idle state, and back-to-back writes are accepted every cycle.
// A query holds s_tready low from acceptance until the block is idle again, so a new word waits
// until the query is through: nine reads through the single map port, a drain and a setup state,
// nine steps of the two restoring dividers and a final state that loads the output register.
// A stalled output holds its word; a new word is still accepted meanwhile, and a query
// then waits in its last cycle until the output register frees up.
// Reset clears the bias to zero; the depth map holds no defined contents until written.
module pcf_shadow_map_query_core #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // map_x[9:0], map_y[19:10], depth[35:20], zero[39:36]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // passing_count[3:0], usable_count[7:4],
	                               // shadow_fraction[16:8], light_scale[25:17], zero[31:26]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import pcfsm_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic [3:0] passing_count, usable_count;
	logic [8:0] shadow_fraction, light_scale;

	pcfsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	pcfsm_dp #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_x            (s_tdata[9:0]),
		.in_y            (s_tdata[19:10]),
		.in_depth        (s_tdata[35:20]),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.passing_count   (passing_count),
		.usable_count    (usable_count),
		.shadow_fraction (shadow_fraction),
		.light_scale     (light_scale)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {6'b0, light_scale, shadow_fraction, usable_count, passing_count};

endmodule

// ----- src/pcfsm_checker.sv -----
module pcfsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import pcfsm_pkg::*;

	logic [3:0] pc, uc;
	logic [8:0] fr, ls;

	assign pc = m_tdata[3:0];
	assign uc = m_tdata[7:4];
	assign fr = m_tdata[16:8];
	assign ls = m_tdata[25:17];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pc <= uc && uc <= 4'd9)
		else $error("sample counts out of range");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && uc == 4'd0 |-> fr == 9'd0 && ls == LIGHT_EMPTY)
		else $error("empty window gave a nonzero fraction");

	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && uc != 4'd0 |-> ((fr == 9'd256) == (pc == uc))
			&& ls >= LIGHT_EMPTY && ls <= 9'd256)
		else $error("fraction or light scale inconsistent with counts");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_WRITE |=> s_tready)
		else $error("write word did not complete in one cycle");

endmodule

bind pcf_shadow_map_query_core pcfsm_checker u_pcfsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/pcf_shadow_map_query_core_tb.sv -----
module pcf_shadow_map_query_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcfsm_pkg::*;

	localparam int MAP_W         = 256;
	localparam int MAP_H         = 256;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD     = 400;
	localparam int DEPTH_BAND    = 32768;
	localparam int DARK_LIGHT    = 77;

	typedef struct packed {
		logic               op;
		logic        [15:0] depth;
		logic signed [9:0]  y;
		logic signed [9:0]  x;
	} map_word_t;

	// Same bit order as m_tdata[25:0].
	typedef struct packed {
		logic [8:0] light;
		logic [8:0] fraction;
		logic [3:0] usable;
		logic [3:0] passing;
	} shade_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // map_x[9:0], map_y[19:10], depth[35:20], zero[39:36]
	logic        s_tuser   = 1'b0; // op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // passing[3:0], usable[7:4], fraction[16:8], light[25:17]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	pcf_shadow_map_query_core #(
		.MAP_WIDTH (MAP_W),
		.MAP_HEIGHT(MAP_H)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Predictor state: the depth map as the block should hold it, and the live bias.
	logic        [15:0] shadow_mem [MAP_W*MAP_H];
	logic signed [15:0] bias_cur = '0;
	shade_t             shade_q [$];

	// Generator state: which cells the queued words will have written, and their depths.
	bit          gen_written [MAP_W*MAP_H];
	logic [15:0] gen_depth   [MAP_W*MAP_H];
	int          gen_bias = 0;
	map_word_t   word_q [$];
	int          n_pushed = 0;

	bit tx_idle_en  = 1'b1;
	bit rx_idle_en  = 1'b1;
	bit stall_req   = 1'b0;
	bit stall_taken = 1'b0;
	bit in_fire     = 1'b0;
	int tx_gap      = 0;
	int rx_gap      = 0;
	int hold_left   = 0;
	int cyc         = 0;
	int errors      = 0;
	int n_writes    = 0;
	int n_offmap    = 0;
	int n_queries   = 0;
	int n_results   = 0;
	int n_dark      = 0;
	int n_full      = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit on_map(int x, int y);
		return x >= 0 && y >= 0 && x < MAP_W && y < MAP_H;
	endfunction

	// Applies one accepted word to the predicted map; returns 1 with the filter result for a query.
	function automatic bit shade_eval(input map_word_t w, output shade_t r);
		int cx, cy, px, py, thresh, pass, usable, frac, light;
		cx = $signed(w.x);
		cy = $signed(w.y);
		r = '0;
		if (w.op == OP_WRITE) begin
			if (on_map(cx, cy))
				shadow_mem[cx*MAP_H + cy] = w.depth;
			return 1'b0;
		end
		thresh = w.depth;
		thresh = thresh + bias_cur;
		pass = 0;
		usable = 0;
		for (int dx = -1; dx <= 1; dx++) begin
			for (int dy = -1; dy <= 1; dy++) begin
				px = cx + dx;
				py = cy + dy;
				if (on_map(px, py)) begin
					usable++;
					if (int'(shadow_mem[px*MAP_H + py]) < thresh)
						pass++;
				end
			end
		end
		if (usable == 0) begin
			frac = 0;
			light = DARK_LIGHT;
		end else begin
			frac = (512*pass + usable) / (2*usable);
			light = (1546*usable + 3584*pass) / (20*usable);
		end
		r.passing = 4'(pass);
		r.usable = 4'(usable);
		r.fraction = 9'(frac);
		r.light = 9'(light);
		return 1'b1;
	endfunction

	task automatic check_field(string name, logic [8:0] expv, logic [8:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endtask

	task automatic push_word(logic op, int x, int y, int d);
		map_word_t w;
		w.op = op;
		w.x = 10'(x);
		w.y = 10'(y);
		w.depth = 16'(d);
		word_q.push_back(w);
		n_pushed++;
		if (op == OP_WRITE && on_map(x, y)) begin
			gen_written[x*MAP_H + y] = 1'b1;
			gen_depth[x*MAP_H + y] = 16'(d);
		end
	endtask

	function automatic int pick_store_depth();
		case ($urandom_range(0, 5))
			0, 1: return $urandom_range(0, 65535);
			2, 3: return DEPTH_BAND + int'($urandom_range(0, 16)) - 8;
			4: return 0;
			default: return 65535;
		endcase
	endfunction

	// Query depths cluster around stored values so that the biased comparison lands on ties.
	function automatic int pick_query_depth(int x, int y);
		int t;
		case ($urandom_range(0, 7))
			0, 1: return $urandom_range(0, 65535);
			2, 3: t = DEPTH_BAND - gen_bias + int'($urandom_range(0, 16)) - 8;
			4, 5: begin
				if (on_map(x, y)) begin
					t = gen_depth[x*MAP_H + y];
					t = t - gen_bias + int'($urandom_range(0, 2)) - 1;
				end else begin
					t = $urandom_range(0, 65535);
				end
			end
			6: return 0;
			default: return 65535;
		endcase
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return t;
	endfunction

	// Every on-map neighbor gets written first, so no query ever reads an unwritten cell.
	task automatic push_query(int x, int y, int d);
		int px, py;
		for (int dx = -1; dx <= 1; dx++) begin
			for (int dy = -1; dy <= 1; dy++) begin
				px = x + dx;
				py = y + dy;
				if (on_map(px, py) && !gen_written[px*MAP_H + py])
					push_word(OP_WRITE, px, py, pick_store_depth());
			end
		end
		if (d < 0)
			d = pick_query_depth(x, y);
		push_word(OP_QUERY, x, y, d);
	endtask

	task automatic pick_coords(output int x, output int y);
		int r, e;
		int edge_vals [6] = '{-2, -1, 0, 255, 256, 257};
		r = $urandom_range(0, 19);
		if (r < 10) begin
			x = $urandom_range(120, 135);
			y = $urandom_range(120, 135);
		end else if (r < 14) begin
			x = $urandom_range(0, 1) ? int'($urandom_range(0, 3)) - 1 : 253 + int'($urandom_range(0, 3));
			y = $urandom_range(0, 1) ? int'($urandom_range(0, 3)) - 1 : 253 + int'($urandom_range(0, 3));
		end else if (r < 17) begin
			e = edge_vals[$urandom_range(0, 5)];
			if ($urandom_range(0, 1)) begin
				x = e;
				y = $urandom_range(120, 135);
			end else begin
				x = $urandom_range(120, 135);
				y = e;
			end
		end else if (r < 19) begin
			x = int'($urandom_range(0, 1023)) - 512;
			y = int'($urandom_range(0, 1023)) - 512;
		end else begin
			x = $urandom_range(0, 255);
			y = $urandom_range(0, 255);
		end
	endtask

	task automatic random_phase(int n_items);
		int stop, x, y;
		stop = n_pushed + n_items;
		while (n_pushed < stop) begin
			pick_coords(x, y);
			if ($urandom_range(0, 9) < 4)
				push_word(OP_WRITE, x, y, pick_store_depth());
			else
				push_query(x, y, -1);
		end
	endtask

	// Waits until every word is taken and every result is back, then lets the block settle.
	task automatic drain();
		while (word_q.size() != 0 || s_tvalid || shade_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bias(int v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = 16'(v);
		do @(posedge clk); while (!cfg_ready);
		bias_cur = 16'(v);
		gen_bias = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		map_word_t w;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (tx_gap == 0 && tx_idle_en && $urandom_range(0, 4) == 0)
				tx_gap = $urandom_range(1, 7);
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (word_q.size() != 0) begin
				w = word_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, w.depth, w.y, w.x};
				s_tuser <= w.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The long hold lets the sender keep offering words until the block backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_req && !stall_taken) begin
				stall_taken = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (rx_gap == 0 && rx_idle_en && $urandom_range(0, 5) == 0)
				rx_gap = $urandom_range(1, 7);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		map_word_t w;
		shade_t exp_s, got;
		in_fire = s_tvalid && s_tready;
		if (arst_n && in_fire) begin
			w.op = s_tuser;
			w.x = s_tdata[9:0];
			w.y = s_tdata[19:10];
			w.depth = s_tdata[35:20];
			if (w.op == OP_WRITE) begin
				n_writes++;
				if (!on_map($signed(w.x), $signed(w.y)))
					n_offmap++;
			end else begin
				n_queries++;
			end
			if (shade_eval(w, exp_s))
				shade_q.push_back(exp_s);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[25:0];
			if (shade_q.size() == 0) begin
				$error("result word 0x%h arrived with no query outstanding", m_tdata);
				errors++;
			end else begin
				exp_s = shade_q.pop_front();
				n_results++;
				if (exp_s.usable == 0)
					n_dark++;
				if (exp_s.usable == 9)
					n_full++;
				check_field("passing_count", exp_s.passing, got.passing);
				check_field("usable_count", exp_s.usable, got.usable);
				check_field("shadow_fraction", exp_s.fraction, got.fraction);
				check_field("light_scale", exp_s.light, got.light);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.", cyc, shade_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_bias(0);
		push_word(OP_WRITE, 0, 0, 0);
		push_word(OP_WRITE, 255, 255, 65535);
		push_word(OP_WRITE, -512, -512, 16'hA5A5);
		push_word(OP_WRITE, 511, 511, 16'h5A5A);
		push_word(OP_WRITE, 256, 0, 1);
		push_query(0, 0, 1);
		push_query(-1, -1, 65535);
		push_query(1, -1, DEPTH_BAND);
		push_query(1, 1, 65535);
		push_query(255, 255, 0);
		push_query(256, 256, 65535);
		// Windows lying wholly off the map.
		push_query(-512, 511, 65535);
		push_query(300, -300, 0);
		drain();

		set_bias(-32768);
		random_phase(180);
		drain();

		set_bias(32767);
		random_phase(180);
		drain();

		set_bias(int'($urandom_range(0, 65535)) - 32768);
		stall_req = 1'b1;
		random_phase(250);
		drain();

		set_bias(int'($urandom_range(0, 6)) - 3);
		random_phase(250);
		drain();

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		set_bias(int'($urandom_range(0, 65535)) - 32768);
		random_phase(200);
		drain();

		$display("Sent %0d map writes (%0d off the map) and %0d filtered queries under six biases.",
			n_writes, n_offmap, n_queries);
		$display("Checked %0d results: %0d with no usable sample, %0d with a full 3x3 window.",
			n_results, n_dark, n_full);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
